// ----- sv/dds_pkg.sv -----
// ============================================================================
// dds_pkg: shared definitions for the decimal digit seven-segment scanner
// Widths, segment table, divide-by-ten constants and the front/back entry.
// ============================================================================
package dds_pkg;

    localparam int NUMBER_W          = 16;
    localparam int PORT_W            = 12;
    localparam int SEG_W             = 7;
    localparam int DIGIT_W           = 4;
    localparam int DIGIT_IDX_W       = 3;
    localparam int DEFAULT_NUM_RANKS = 4;
    localparam int QUEUE_DEPTH       = 2;

    // Digit index of the most significant digit, by range of the number
    localparam logic [DIGIT_IDX_W-1:0] IDX_ONE   = 3'd0;
    localparam logic [DIGIT_IDX_W-1:0] IDX_TWO   = 3'd1;
    localparam logic [DIGIT_IDX_W-1:0] IDX_THREE = 3'd2;
    localparam logic [DIGIT_IDX_W-1:0] IDX_FOUR  = 3'd3;
    localparam logic [DIGIT_IDX_W-1:0] IDX_FIVE  = 3'd4;

    localparam logic [NUMBER_W-1:0] TEN         = 16'd10;
    localparam logic [NUMBER_W-1:0] HUNDRED     = 16'd100;
    localparam logic [NUMBER_W-1:0] THOUSAND    = 16'd1000;
    localparam logic [NUMBER_W-1:0] TEN_THOUSAND = 16'd10000;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [NUMBER_W-1:0] DIV10_RECIP = 16'hCCCD;
    localparam int                  DIV10_SHIFT = 19;

    // Digit select for rank 0; higher ranks shift left, past bit 11 drops out
    localparam logic [PORT_W-1:0] SEL_BASE = 12'h100;

    typedef struct packed {
        logic [NUMBER_W-1:0]    number;
        logic [DIGIT_IDX_W-1:0] last_idx;
    } front_entry_t;

    // Common-cathode segments a..g
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 7'h3f;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5b;
            4'd3:    code = 7'h4f;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6d;
            4'd6:    code = 7'h7d;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7f;
            4'd9:    code = 7'h6f;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

// ----- sv/decimal_digit_seven_segment_scanner.sv -----
// ============================================================================
// decimal_digit_seven_segment_scanner: number to multiplexed display words
// Splits a 16-bit number into decimal digits and emits one port word each.
// ============================================================================
// Push an unsigned 16-bit number; the block returns one 12-bit port word per
// decimal digit, least significant digit first (a zero gives one word). Bits
// 0..6 hold segments a..g (common cathode), bit 7 is zero, and bits 8..11
// hold a one-hot digit select taken from a rank that counts 0..NUM_RANKS per
// number and is used modulo NUM_RANKS; a select past bit 11 reads as zero.
// The word of the most significant digit has last set. A number has 1 to 5
// digits. The digit sequencer handles one digit per cycle, while the output
// word is free, with a reciprocal divide-by-ten; back-to-back numbers stream
// out with no gap between them while pop is held. A pushed number is queued,
// loaded into the sequencer, and its first digit is registered as the output
// word. A two-entry queue sits between the input classifier and the sequencer,
// so a stalled consumer does not stop input transfers until the queue fills.
// ============================================================================
module decimal_digit_seven_segment_scanner
    import dds_pkg::*;
#(
    parameter int NUM_RANKS = DEFAULT_NUM_RANKS
) (
    input  logic                clk,
    input  logic                rst_n,
    // input queue side: transfer when push && !full
    input  logic                push,
    output logic                full,
    input  logic [NUMBER_W-1:0] number,
    // result queue side: transfer when pop && !empty
    output logic                empty,
    input  logic                pop,
    output logic [PORT_W-1:0]   port_word,
    output logic                last
);

    front_entry_t entry;
    logic         entry_valid;
    logic         entry_take;

    // front: classify by digit count, buffer
    dds_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .number      (number),
        .full        (full),
        .entry_take  (entry_take),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    // back: one digit per cycle into the output register while it is free
    dds_back #(
        .NUM_RANKS (NUM_RANKS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (entry_valid),
        .entry       (entry),
        .entry_take  (entry_take),
        .empty       (empty),
        .pop         (pop),
        .port_word   (port_word),
        .last        (last)
    );

endmodule

// ----- sv/dds_queue.sv -----
// ============================================================================
// dds_queue: small register queue
// Decouples the classifying front from the digit-emitting back.
// ============================================================================
module dds_queue #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/dds_front.sv -----
// ============================================================================
// dds_front: input side
// Takes numbers, finds the digit count and queues them for the back end.
// ============================================================================
module dds_front
    import dds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [NUMBER_W-1:0] number,
    output logic                full,
    input  logic                entry_take,
    output logic                entry_valid,
    output front_entry_t        entry
);

    localparam int ENTRY_W = $bits(front_entry_t);

    front_entry_t         classified;
    logic [ENTRY_W-1:0]   rd_bits;

    // index of the most significant digit
    always_comb
    begin
        classified.number = number;
        if (number >= TEN_THOUSAND)
        begin
            classified.last_idx = IDX_FIVE;
        end
        else if (number >= THOUSAND)
        begin
            classified.last_idx = IDX_FOUR;
        end
        else if (number >= HUNDRED)
        begin
            classified.last_idx = IDX_THREE;
        end
        else if (number >= TEN)
        begin
            classified.last_idx = IDX_TWO;
        end
        else
        begin
            classified.last_idx = IDX_ONE;
        end
    end

    dds_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_data   (classified),
        .full      (full),
        .rd_en     (entry_take),
        .rd_data   (rd_bits),
        .not_empty (entry_valid)
    );

    assign entry = front_entry_t'(rd_bits);

endmodule

// ----- sv/dds_back.sv -----
// ============================================================================
// dds_back: digit sequencer
// Peels one decimal digit per cycle while the output word is free and builds the display port word.
// ============================================================================
module dds_back
    import dds_pkg::*;
#(
    parameter int NUM_RANKS = DEFAULT_NUM_RANKS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              entry_valid,
    input  front_entry_t      entry,
    output logic              entry_take,
    output logic              empty,
    input  logic              pop,
    output logic [PORT_W-1:0] port_word,
    output logic              last
);

    localparam int RANK_W = $clog2(NUM_RANKS + 1);

    logic                   busy_reg, busy_next;
    logic [NUMBER_W-1:0]    value_reg, value_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic [DIGIT_IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [RANK_W-1:0]      rank_reg, rank_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PORT_W-1:0]      word_reg, word_next;
    logic                   last_reg, last_next;

    logic [2*NUMBER_W-1:0]  prod;
    logic [NUMBER_W-1:0]    quot;
    logic [NUMBER_W-1:0]    ten_quot;
    logic [NUMBER_W-1:0]    rem;
    logic [RANK_W-1:0]      rank_mod;
    logic [PORT_W-1:0]      sel;
    logic                   out_free, step, finishing;

    // value / 10 by reciprocal, remainder by shift-add
    assign prod     = (2*NUMBER_W)'(value_reg) * (2*NUMBER_W)'(DIV10_RECIP);
    assign quot     = NUMBER_W'(prod >> DIV10_SHIFT);
    assign ten_quot = (quot << 3) + (quot << 1);
    assign rem      = value_reg - ten_quot;

    // rank runs 0..NUM_RANKS, so mod is a single compare
    assign rank_mod = (rank_reg == RANK_W'(NUM_RANKS)) ? '0 : rank_reg;
    assign sel      = SEL_BASE << rank_mod;

    assign out_free   = !out_valid_reg || pop;
    assign step       = busy_reg && out_free;
    assign finishing  = step && (idx_reg == last_idx_reg);
    assign entry_take = entry_valid && (!busy_reg || finishing);

    always_comb
    begin
        busy_next      = busy_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        rank_next      = rank_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
            word_next      = sel | PORT_W'(seg_code(rem[DIGIT_W-1:0]));
            last_next      = (idx_reg == last_idx_reg);
            value_next     = quot;
            idx_next       = idx_reg + 1'b1;
            rank_next      = (rank_reg == RANK_W'(NUM_RANKS)) ? '0 : rank_reg + 1'b1;
            if (finishing)
            begin
                busy_next = 1'b0;
            end
        end
        if (entry_take)
        begin
            busy_next     = 1'b1;
            value_next    = entry.number;
            last_idx_next = entry.last_idx;
            idx_next      = '0;
            rank_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        word_reg  <= word_next;
        last_reg  <= last_next;
    end

    assign empty     = !out_valid_reg;
    assign port_word = word_reg;
    assign last      = last_reg;

endmodule

// ----- sv/dds_checker.sv -----
// ============================================================================
// dds_checker: port-level checks for the scanner
// Watches the result side of the top level; attached by bind.
// ============================================================================
module dds_checker
    import dds_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input logic [PORT_W-1:0]   port_word,
    input logic                last
);

    // nothing is offered once reset has been seen at an edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result offered during reset");

    // a waiting result is not withdrawn
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before transfer");

    // a waiting result does not change
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(port_word) && $stable(last))
        else $error("result changed before transfer");

    // well-formed word: at most one select, bit 7 clear, some segment lit
    a_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $onehot0(port_word[11:8]) && !port_word[7] && (port_word[6:0] != '0))
        else $error("malformed port word");

endmodule

bind decimal_digit_seven_segment_scanner dds_checker u_dds_checker (.*);

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top: regression for the decimal digit seven-segment scanner
// Pushes numbers through the input queue and predicts, in the bench itself,
// one display word per decimal digit (least significant first). Each word
// popped from the result queue is checked against the oldest prediction.
// Both sides idle at random; some stretches run with no gaps at all.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dds_pkg::*;

    // Rank wraps modulo this; the block is built with its default
    localparam int RANKS      = DEFAULT_NUM_RANKS;
    localparam int MAX_DIGITS = 5;

    // Common-cathode segments a..g for digits 0..9
    localparam logic [SEG_W-1:0] SEGMENTS [10] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
    };

    // One result transfer: select/segment word plus the last-digit flag
    typedef struct packed {
        logic [PORT_W-1:0] word;
        logic              last;
    } display_word_t;

    logic                clk;
    logic                rst_n  = 1'b0;
    logic                push   = 1'b0;
    logic [NUMBER_W-1:0] number = '0;
    logic                pop    = 1'b0;
    logic                full;
    logic                empty;
    logic [PORT_W-1:0]   port_word;
    logic                last;

    // Words predicted but not yet popped, oldest first
    display_word_t pending_words[$];

    int err_count = 0;
    int pop_hold  = 0;
    bit no_gaps   = 1'b0;   // when set, neither side idles

    decimal_digit_seven_segment_scanner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .number    (number),
        .empty     (empty),
        .pop       (pop),
        .port_word (port_word),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: the slowest legal run is well under a tenth of this
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Digit predictor. Peels decimal digits off the bottom of the number; a
    // zero still gives one digit. The rank steps 0..RANKS and back to 0, and
    // the select bit is SEL_BASE shifted by rank mod RANKS, so the fifth digit
    // lands on the first select line again. Anything shifted past bit 11
    // falls off the 12-bit word by itself.
    // ------------------------------------------------------------------------
    function automatic void predict_display_words(input logic [NUMBER_W-1:0] value);
        logic [NUMBER_W-1:0] rest;
        int                  rank;
        int                  digit;
        int                  count;
        display_word_t       w;
        rest  = value;
        rank  = 0;
        count = 0;
        do
        begin
            digit  = rest % 10;
            rest   = rest / 10;
            w.word = (SEL_BASE << (rank % RANKS)) | PORT_W'(SEGMENTS[digit]);
            w.last = (rest == 0);
            pending_words.push_back(w);
            count++;
            rank = (rank < RANKS) ? rank + 1 : 0;
        end
        while (rest != 0 && count < MAX_DIGITS);
    endfunction

    // Idle length before a push: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(10, 30);
        if (r < 8)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Push one number. Push is only dropped when a gap follows, so a
    // back-to-back transfer keeps it high with a single update per edge.
    // The transfer happens at the first edge that sees push high, full low.
    // ------------------------------------------------------------------------
    task automatic send_number(input logic [NUMBER_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        number <= value;
        do
            @(posedge clk);
        while (full);
        predict_display_words(value);
    endtask

    // ------------------------------------------------------------------------
    // Result side: check the word at each pop transfer, then pick pop for the
    // next cycle. Short stalls are common, long ones rare.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        display_word_t exp_word;
        int            r;
        if (pop && !empty)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result: port_word=%h last=%b", port_word, last);
                err_count++;
            end
            else
            begin
                exp_word = pending_words.pop_front();
                if (port_word !== exp_word.word)
                begin
                    $error("port_word mismatch: expected %h, got %h",
                           exp_word.word, port_word);
                    err_count++;
                end
                if (last !== exp_word.last)
                begin
                    $error("last mismatch: expected %b, got %b", exp_word.last, last);
                    err_count++;
                end
            end
        end
        if (no_gaps)
        begin
            pop_hold = 0;
            pop <= 1'b1;
        end
        else if (pop_hold > 0)
        begin
            pop_hold--;
            pop <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                pop_hold = $urandom_range(10, 40);
                pop <= 1'b0;
            end
            else if (r < 6)
            begin
                pop_hold = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Zero: a single word, first select line, segments for 0, last set
    task automatic test_zero();
        send_number('0);
    endtask

    // Every digit count from one to five, at both ends of each range, with 1 as the low end for one digit
    task automatic test_digit_lengths();
        send_number(16'd1);
        send_number(16'd9);
        send_number(16'd10);
        send_number(16'd99);
        send_number(16'd100);
        send_number(16'd999);
        send_number(16'd1000);
        send_number(16'd9999);
        send_number(16'd10000);
        send_number(16'd65535);
    endtask

    // Every digit value and every select line in use; five-digit numbers wrap the rank
    task automatic test_every_digit();
        send_number(16'd12345);
        send_number(16'd60789);
        send_number(16'd9876);
        send_number(16'd54321);
        send_number(16'd10203);
        send_number(16'd43210);
    endtask

    // Streams with no idling on either side, so numbers run back to back
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        send_number(16'd65534);
        send_number(16'd7);
        send_number(16'd40506);
        send_number(16'd88);
        send_number(16'd0);
        send_number(16'd31415);
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random numbers: the digit count is drawn first so short and long
    // numbers are equally likely; a quarter are raw 16-bit values. Idling
    // is switched off for some stretches of 40 transfers.
    // ------------------------------------------------------------------------
    task automatic test_random(input int n_items);
        int digits;
        int lo;
        int hi;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                send_number(NUMBER_W'($urandom));
            else
            begin
                digits = $urandom_range(1, MAX_DIGITS);
                lo     = (digits == 1) ? 0 : 10 ** (digits - 1);
                hi     = (digits == MAX_DIGITS) ? 65535 : 10 ** digits - 1;
                send_number(NUMBER_W'($urandom_range(lo, hi)));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero();
        test_digit_lengths();
        test_every_digit();
        test_back_to_back();
        test_random(230);
        push <= 1'b0;

        // Drain, then give any stray word time to show up
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_count == 0 && pending_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
